FILE: rtl/bca_pkg.sv
package bca_pkg;

   // geometry
   localparam int MAP_WORDS  = 16;
   localparam int NUM_CHUNKS = 512;
   localparam int BATCH_SIZE = 4;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int SPAN_BITS  = MAP_WORDS * WORD_BITS;
   localparam int LIMIT      = (NUM_CHUNKS < SPAN_BITS) ? NUM_CHUNKS : SPAN_BITS;

   // field widths
   localparam int CMD_W    = 2;
   localparam int CHUNK_W  = 9;
   localparam int STATUS_W = 2;

   // internal widths
   localparam int HINT_W    = $clog2(LIMIT + 1);
   localparam int WI_W      = $clog2(MAP_WORDS + 1);
   localparam int MAP_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC_ONE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC_FOUR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE       = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_CHUNKS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE  = 2'd2;

   typedef enum logic [2:0] {
      EMIT_NONE  = 3'd0,
      EMIT_TAKE  = 3'd1,
      EMIT_FAIL  = 3'd2,
      EMIT_RANGE = 3'd3,
      EMIT_FREE  = 3'd4
   } emit_type;

   typedef struct packed {
      logic     load_word;  // scan pointer from the hint
      logic     step_word;  // scan pointer to the next word
      logic     take;       // clear leading free bit of current word
      logic     free;       // set the bit of the requested chunk
      emit_type emit;
      logic     emit_last;
   } dp_ctrl_type;

   typedef struct packed {
      logic word_past_end;
      logic word_zero;
      logic rest_zero;
      logic take_at_limit;
      logic hint_at_limit;
      logic free_out_of_range;
   } dp_stat_type;

   // reset content of one bitmap word: chunks below the limit free
   function automatic logic [WORD_BITS-1:0] map_reset_word(input int w);
      int base;
      logic [WORD_BITS-1:0] word;
      base = w * WORD_BITS;
      if (base + WORD_BITS <= LIMIT) begin
         word = '1;
      end else if (base >= LIMIT) begin
         word = '0;
      end else begin
         word = ~({WORD_BITS{1'b1}} >> (LIMIT - base));
      end
      return word;
   endfunction

   // position of the most significant set bit, counted from the top
   function automatic logic [BIT_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) begin
            n = BIT_W'(WORD_BITS - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

FILE: rtl/bitmap_chunk_allocator_core.sv
// bitmap chunk allocator: 16 x 32-bit free map, next-free hint, one command at a time
// free, and a batch with the hint at the limit: answered from idle, word in the next cycle, busy stays low
// alloc: accepted from idle, scan pointer loaded from the hint; empty map words from the
//   hint's word on are skipped, then chunks taken; running out ends with an out-of-chunks word
// each word is strobed for a single cycle, cannot be stalled; next command taken with the final word
// synchronous reset marks every chunk free, clears the hint and returns to idle
module bitmap_chunk_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bca_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bca_pkg::CHUNK_W-1:0]   req_freed_chunk,
   output logic                          rsp_valid,
   output logic [bca_pkg::CHUNK_W-1:0]   rsp_chunk_number,
   output logic [bca_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   import bca_pkg::*;

   dp_ctrl_type ctrl;   // controller commands to the datapath
   dp_stat_type stat;   // datapath flags back to the controller

   // sequencer: idle, word scan, trailing failure word
   bca_controller u_controller (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   // free map, hint, scan pointer, leading-one pick and the result registers
   bca_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_freed_chunk  (req_freed_chunk),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   // error words always close the command and carry chunk zero
   error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last && (rsp_chunk_number == '0))
      else $error("error word not final or carries a chunk");

   // an accepted free answers in the very next cycle with a single word
   free_answers_next: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_FREE) |=> rsp_valid && rsp_last)
      else $error("free command gave no final word");

   // no new command while the previous one is still producing words
   no_word_after_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final word while the block is idle");

endmodule

FILE: rtl/bca_datapath.sv
module bca_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bca_pkg::CHUNK_W-1:0]   req_freed_chunk,
   input  bca_pkg::dp_ctrl_type          ctrl,
   output bca_pkg::dp_stat_type          stat,
   output logic                          rsp_valid,
   output logic [bca_pkg::CHUNK_W-1:0]   rsp_chunk_number,
   output logic [bca_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   import bca_pkg::*;

   logic [WORD_BITS-1:0] map_ff [MAP_WORDS];
   logic [WORD_BITS-1:0] map_in [MAP_WORDS];
   logic [HINT_W-1:0]    hint_ff, hint_in;
   logic [WI_W-1:0]      word_ff, word_in;

   logic                 valid_ff, valid_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 last_ff, last_in;

   logic                 past_end;
   logic [MAP_IDX_W-1:0] word_idx;
   logic [WORD_BITS-1:0] cur_word;
   logic [BIT_W-1:0]     lead_pos;
   logic [WORD_BITS-1:0] take_mask;
   logic [WORD_BITS-1:0] rest_word;
   logic [CHUNK_W-1:0]   take_chunk;
   logic [HINT_W-1:0]    take_hint;
   logic [HINT_W-1:0]    freed_wide;
   logic [MAP_IDX_W-1:0] free_idx;
   logic [WORD_BITS-1:0] free_mask;

   assign past_end   = (word_ff >= WI_W'(MAP_WORDS));
   assign word_idx   = word_ff[MAP_IDX_W-1:0];
   assign cur_word   = past_end ? '0 : map_ff[word_idx];
   assign lead_pos   = lead_zeros(cur_word);
   assign take_mask  = {1'b1, {(WORD_BITS-1){1'b0}}} >> lead_pos;
   assign rest_word  = cur_word & ~take_mask;
   assign take_chunk = CHUNK_W'({word_idx, lead_pos});
   assign take_hint  = HINT_W'(take_chunk) + HINT_W'(1);
   assign freed_wide = HINT_W'(req_freed_chunk);
   assign free_idx   = MAP_IDX_W'(req_freed_chunk >> BIT_W);
   assign free_mask  = {1'b1, {(WORD_BITS-1){1'b0}}} >> req_freed_chunk[BIT_W-1:0];

   always_comb begin
      stat.word_past_end     = past_end;
      stat.word_zero         = (cur_word == '0);
      stat.rest_zero         = (rest_word == '0);
      stat.take_at_limit     = (take_hint >= HINT_W'(LIMIT));
      stat.hint_at_limit     = (hint_ff >= HINT_W'(LIMIT));
      stat.free_out_of_range = (freed_wide >= HINT_W'(LIMIT));
   end

   // per-word update, each word touched only at its own place
   always_comb begin
      for (int i = 0; i < MAP_WORDS; i++) begin
         map_in[i] = map_ff[i];
         if (ctrl.take && (word_idx == MAP_IDX_W'(i))) begin
            map_in[i] = rest_word;
         end else if (ctrl.free && (free_idx == MAP_IDX_W'(i))) begin
            map_in[i] = map_ff[i] | free_mask;
         end
      end
   end

   always_comb begin
      hint_in = hint_ff;
      if (ctrl.take) begin
         hint_in = take_hint;
      end else if (ctrl.free && (hint_ff >= freed_wide)) begin
         hint_in = freed_wide;
      end
   end

   always_comb begin
      word_in = word_ff;
      if (ctrl.load_word) begin
         word_in = WI_W'(hint_ff >> BIT_W);
      end else if (ctrl.step_word) begin
         word_in = word_ff + WI_W'(1);
      end
   end

   always_comb begin
      valid_in  = 1'b1;
      chunk_in  = '0;
      status_in = STATUS_OK;
      last_in   = 1'b1;
      case (ctrl.emit)
         EMIT_TAKE: begin
            chunk_in = take_chunk;
            last_in  = ctrl.emit_last;
         end
         EMIT_FAIL: begin
            status_in = STATUS_OUT_OF_CHUNKS;
         end
         EMIT_RANGE: begin
            status_in = STATUS_OUT_OF_RANGE;
         end
         EMIT_FREE: begin
            chunk_in = req_freed_chunk;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_WORDS; i++) begin
            map_ff[i] <= map_reset_word(i);
         end
         hint_ff  <= '0;
         word_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         map_ff   <= map_in;
         hint_ff  <= hint_in;
         word_ff  <= word_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff  <= chunk_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_chunk_number = chunk_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

   hint_bounded: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= HINT_W'(LIMIT))
      else $error("next-free hint beyond chunk limit");

   take_has_free_bit: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> !stat.word_zero && !stat.word_past_end)
      else $error("take issued on an empty or missing word");

endmodule

FILE: rtl/bca_controller.sv
module bca_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bca_pkg::CMD_W-1:0]   req_cmd,
   input  bca_pkg::dp_stat_type        stat,
   output bca_pkg::dp_ctrl_type        ctrl,
   output logic                        busy
);
   import bca_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FAIL = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             batch_ff, batch_in;
   logic             take_last;

   assign take_last = !batch_ff || (cnt_ff == CNT_W'(BATCH_SIZE - 1));

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      batch_in       = batch_ff;
      ctrl.load_word = 1'b0;
      ctrl.step_word = 1'b0;
      ctrl.take      = 1'b0;
      ctrl.free      = 1'b0;
      ctrl.emit      = EMIT_NONE;
      ctrl.emit_last = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_ALLOC_ONE: begin
                     ctrl.load_word = 1'b1;
                     batch_in       = 1'b0;
                     cnt_in         = '0;
                     state_in       = ST_SCAN;
                  end
                  CMD_ALLOC_FOUR: begin
                     if (stat.hint_at_limit) begin
                        ctrl.emit = EMIT_FAIL;
                     end else begin
                        ctrl.load_word = 1'b1;
                        batch_in       = 1'b1;
                        cnt_in         = '0;
                        state_in       = ST_SCAN;
                     end
                  end
                  CMD_FREE: begin
                     if (stat.free_out_of_range) begin
                        ctrl.emit = EMIT_RANGE;
                     end else begin
                        ctrl.free = 1'b1;
                        ctrl.emit = EMIT_FREE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.word_past_end) begin
               ctrl.emit = EMIT_FAIL;
               state_in  = ST_IDLE;
            end else if (stat.word_zero) begin
               ctrl.step_word = 1'b1;
            end else begin
               ctrl.take      = 1'b1;
               ctrl.emit      = EMIT_TAKE;
               ctrl.emit_last = take_last;
               if (take_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (stat.rest_zero) begin
                     if (stat.take_at_limit) begin
                        state_in = ST_FAIL;
                     end else begin
                        ctrl.step_word = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FAIL: begin
            ctrl.emit = EMIT_FAIL;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         batch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         batch_ff <= batch_in;
      end
   end

   assign busy = reset || (state_ff != ST_IDLE);

   single_step_word: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.load_word && ctrl.step_word))
      else $error("scan pointer loaded and stepped together");

   free_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.free |-> (state_ff == ST_IDLE) && start)
      else $error("free outside an accepted command");

   fail_ends_command: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FAIL) |=> (state_ff == ST_IDLE))
      else $error("out-of-chunks word did not end the command");

endmodule
